// ===== design/lzhuf_pkg.sv =====
// Shared types, constants and the position-code table for the LZHUF decoder.
// Used by the top level lzhuf_adaptive_huffman_decoder; depends on nothing.

package lzhuf_pkg;

    localparam int MAX_MATCH      = 60;
    localparam int NSYM           = 256 + MAX_MATCH - 2;
    localparam int TNODES         = 2 * NSYM - 1;
    localparam int ROOT           = TNODES - 1;
    localparam int PAR_DEPTH      = TNODES + NSYM;
    localparam int CNT_DEPTH      = TNODES + 1;
    localparam int NODE_W         = $clog2(PAR_DEPTH);
    localparam int SYM_W          = $clog2(NSYM);
    localparam int LEN_W          = 6;
    localparam int COUNT_W        = 16;
    localparam int RING_SIZE_DEF  = 8192;
    localparam int TAIL_SLACK_DEF = 8;

    typedef logic [NODE_W-1:0]  node_t;
    typedef logic [COUNT_W-1:0] count_t;

    localparam node_t  N_TNODES     = node_t'(TNODES);
    localparam node_t  N_NSYM       = node_t'(NSYM);
    localparam node_t  N_ROOT       = node_t'(ROOT);
    localparam node_t  N_PAR_DEPTH  = node_t'(PAR_DEPTH);
    localparam node_t  N_NSYM_LAST  = node_t'(NSYM - 1);
    localparam node_t  N_WALK_START = node_t'(2 * (ROOT - NSYM));
    localparam count_t COUNT_LIMIT  = 16'h8000;
    localparam count_t COUNT_SENT   = 16'hffff;
    localparam logic [7:0] FILL_BYTE = 8'h20;
    localparam logic [SYM_W-1:0] MATCH_BIAS = SYM_W'(253);

    localparam int POS_GROUPS [6] = '{1, 3, 8, 12, 24, 16};

    typedef enum logic [0:0] {
        CFG_PLAIN_LENGTH = 1'b0,
        CFG_STREAM_BYTES = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FINAL = 2'd1,
        ST_ERROR = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        FIN_RUN  = 2'd0,
        FIN_DONE = 2'd1,
        FIN_ERR  = 2'd2
    } fin_t;

    typedef enum logic [1:0] {
        PH_WALK  = 2'd0,
        PH_BYTE  = 2'd1,
        PH_EXTRA = 2'd2
    } phase_t;

    typedef enum logic [5:0] {
        S_INIT_LEAF, S_INIT_RA, S_INIT_RB, S_INIT_W, S_INIT_W2, S_INIT_FIN,
        S_IDLE, S_FAIL, S_WALK_CHILD,
        S_BUMP_ROOTW, S_BUMP_LEAF, S_BUMP_LEAFW, S_BUMP_TOP, S_BUMP_INC,
        S_BUMP_CMP, S_BUMP_SCAN, S_SWAP1, S_SWAP2, S_SWAP3, S_SWAP4, S_SWAP5,
        S_BUMP_UP, S_BUMP_UPW, S_BUMP_ENDW,
        S_RB_RD, S_RB_CMP, S_RB_RA, S_RB_RB, S_RB_SUM, S_RB_SRCH, S_RB_SH,
        S_RB_SHW, S_RB_PR, S_RB_PW, S_RB_PW2,
        S_LIT, S_MATCH_CHK, S_COPY_RD, S_COPY_OUT
    } state_t;

    typedef struct packed {
        logic [3:0] len;
        logic [5:0] code;
    } pos_code_t;

    // Decode the first byte of a position into its code length and upper code.
    function automatic pos_code_t pos_lookup(input logic [7:0] b);
        pos_code_t  res;
        logic [8:0] base;
        logic [8:0] width;
        logic [8:0] off;
        logic [5:0] sym;
        logic       found;
        res   = '{len: 4'd8, code: 6'd63};
        base  = '0;
        sym   = '0;
        found = 1'b0;
        for (int n = 0; n < 6; n++)
        begin
            width = 9'(POS_GROUPS[n]) << (5 - n);
            if (!found && ({1'b0, b} < base + width))
            begin
                off      = ({1'b0, b} - base) >> (5 - n);
                res.len  = 4'(n + 3);
                res.code = sym + off[5:0];
                found    = 1'b1;
            end
            base = base + width;
            sym  = sym + 6'(POS_GROUPS[n]);
        end
        return res;
    endfunction

endpackage

// ===== design/lzhuf_adaptive_huffman_decoder.sv =====
// Top level of the bit-serial LZHUF decoder: adaptive Huffman tree, position
// code and history ring, all run by one sequencer. Depends on lzhuf_pkg.

// Usage:
// The s_ channel takes one compressed bit per transfer in s_tdata[0], most
// significant bit of each byte first. The m_ channel returns plaintext bytes in
// m_tdata, m_tlast on the last byte caused by one input bit, and the status in
// m_tuser (ok, final byte, stream error). The cfg channel writes plain_length
// (index 0) and stream_bytes (index 1) and is always ready; write it only
// while the decoder is idle.
// After reset the tree memories are loaded with the initial tree; s_tready
// stays low until then. The ring needs no clearing: bytes not yet written
// read as spaces through a fill pointer.
// A position bit is taken directly, a bit inside a symbol code after a read of
// the child memory. A completed symbol walks up the tree through the count,
// parent and child memories, and at each level the count scan may pass further
// nodes. When the root count hits 0x8000 the tree is rebuilt first, its work
// bounded by the insertion shifts. A match copies its bytes one at a time,
// reading each from the ring before showing it, and takes no bit meanwhile.
// The result register holds one byte; when the receiver stalls, the sequencer
// waits on it, and s_tready stays low until the bit's work is finished.

module lzhuf_adaptive_huffman_decoder
    import lzhuf_pkg::*;
#(
    parameter int RING_SIZE  = RING_SIZE_DEF,
    parameter int TAIL_SLACK = TAIL_SLACK_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [0] in_bit, [7:1] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] out_byte
    output logic        m_tlast,
    output logic [1:0]  m_tuser,    // [1:0] status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int RING_AW = $clog2(RING_SIZE);
    localparam logic [RING_AW:0] RING_EXT  = (RING_AW + 1)'(RING_SIZE);
    localparam logic [RING_AW-1:0] RING_LAST = RING_AW'(RING_SIZE - 1);

    // Memories
    count_t cnt_mem [CNT_DEPTH];
    node_t  par_mem [PAR_DEPTH];
    node_t  chd_mem [TNODES];
    logic [7:0] hist_mem [RING_SIZE];

    count_t cnt_rdata_reg;
    node_t  par_rdata_reg;
    node_t  chd_rdata_reg;
    logic [7:0] hist_rdata_reg;

    logic   cnt_re, cnt_we, par_re, par_we, chd_re, chd_we, hist_re, hist_we;
    node_t  cnt_raddr, cnt_waddr, par_raddr, par_waddr, chd_raddr, chd_waddr;
    count_t cnt_wdata;
    node_t  par_wdata, chd_wdata;
    logic [RING_AW-1:0] hist_raddr, hist_waddr;
    logic [7:0] hist_wdata;

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_re)
        begin
            cnt_rdata_reg <= cnt_mem[cnt_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (par_we)
        begin
            par_mem[par_waddr] <= par_wdata;
        end
        if (par_re)
        begin
            par_rdata_reg <= par_mem[par_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (chd_we)
        begin
            chd_mem[chd_waddr] <= chd_wdata;
        end
        if (chd_re)
        begin
            chd_rdata_reg <= chd_mem[chd_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        if (hist_re)
        begin
            hist_rdata_reg <= hist_mem[hist_raddr];
        end
    end

    // Registers
    state_t state_reg, state_next;
    fin_t   fin_reg, fin_next;
    phase_t phase_reg, phase_next;
    node_t  walk_reg, walk_next;
    logic [11:0] acc_reg, acc_next;
    logic [3:0]  bits_left_reg, bits_left_next;
    logic [LEN_W-1:0] pend_reg, pend_next;
    logic [31:0] produced_reg, produced_next;
    logic [34:0] consumed_reg, consumed_next;
    logic [RING_AW-1:0] ring_idx_reg, ring_idx_next;
    logic        wrapped_reg, wrapped_next;
    logic [31:0] plain_len_reg, plain_len_next;
    logic [31:0] stream_bytes_reg, stream_bytes_next;
    logic        bit_reg, bit_next;
    logic [SYM_W-1:0] sym_reg, sym_next;
    node_t  c_reg, c_next;
    node_t  l_reg, l_next;
    node_t  x_reg, x_next;
    node_t  y_reg, y_next;
    node_t  ia_reg, ia_next;
    node_t  ib_reg, ib_next;
    node_t  m_reg, m_next;
    count_t k_reg, k_next;
    count_t ca_reg, ca_next;
    logic [COUNT_W:0] sum_reg, sum_next;
    logic [RING_AW-1:0] src_reg, src_next;
    logic [LEN_W-1:0] copy_left_reg, copy_left_next;
    logic        hist_valid_reg, hist_valid_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        out_last_reg, out_last_next;
    status_t     out_status_reg, out_status_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_INIT_LEAF;
            fin_reg          <= FIN_RUN;
            phase_reg        <= PH_WALK;
            walk_reg         <= N_WALK_START;
            acc_reg          <= '0;
            bits_left_reg    <= '0;
            pend_reg         <= '0;
            produced_reg     <= '0;
            consumed_reg     <= '0;
            ring_idx_reg     <= '0;
            wrapped_reg      <= 1'b0;
            plain_len_reg    <= '0;
            stream_bytes_reg <= 32'd1;
            ia_reg           <= '0;
            ib_reg           <= '0;
            out_valid_reg    <= 1'b0;
            bit_reg          <= 1'b0;
            sym_reg          <= '0;
            c_reg            <= '0;
            l_reg            <= '0;
            x_reg            <= '0;
            y_reg            <= '0;
            m_reg            <= '0;
            k_reg            <= '0;
            ca_reg           <= '0;
            sum_reg          <= '0;
            src_reg          <= '0;
            copy_left_reg    <= '0;
            hist_valid_reg   <= 1'b0;
            out_byte_reg     <= '0;
            out_last_reg     <= 1'b0;
            out_status_reg   <= ST_OK;
        end
        else
        begin
            state_reg        <= state_next;
            fin_reg          <= fin_next;
            phase_reg        <= phase_next;
            walk_reg         <= walk_next;
            acc_reg          <= acc_next;
            bits_left_reg    <= bits_left_next;
            pend_reg         <= pend_next;
            produced_reg     <= produced_next;
            consumed_reg     <= consumed_next;
            ring_idx_reg     <= ring_idx_next;
            wrapped_reg      <= wrapped_next;
            plain_len_reg    <= plain_len_next;
            stream_bytes_reg <= stream_bytes_next;
            ia_reg           <= ia_next;
            ib_reg           <= ib_next;
            out_valid_reg    <= out_valid_next;
            bit_reg          <= bit_next;
            sym_reg          <= sym_next;
            c_reg            <= c_next;
            l_reg            <= l_next;
            x_reg            <= x_next;
            y_reg            <= y_next;
            m_reg            <= m_next;
            k_reg            <= k_next;
            ca_reg           <= ca_next;
            sum_reg          <= sum_next;
            src_reg          <= src_next;
            copy_left_reg    <= copy_left_next;
            hist_valid_reg   <= hist_valid_next;
            out_byte_reg     <= out_byte_next;
            out_last_reg     <= out_last_next;
            out_status_reg   <= out_status_next;
        end
    end

    // Fetched bytes are 1 + ceil(bits/8); overrun when that exceeds the limit.
    logic [32:0] fetch_ceil;
    logic [32:0] fetch_limit;
    logic        overrun;

    assign fetch_ceil  = {1'b0, consumed_reg[34:3]} + 33'(|consumed_reg[2:0]);
    assign fetch_limit = {1'b0, stream_bytes_reg} + 33'(TAIL_SLACK);
    assign overrun     = (fetch_ceil >= fetch_limit);

    logic out_free;
    assign out_free = !out_valid_reg || m_tready;

    logic              emit_en;
    logic [7:0]        emit_val;
    logic              emit_last;
    logic [31:0]       emit_count;
    logic [NODE_W:0]   walk_idx;
    logic [7:0]        acc8;
    logic [3:0]        bl_dec;
    pos_code_t         pc;
    logic [31:0]       owed;
    logic [RING_AW:0]  src_tmp;

    always_comb
    begin
        state_next        = state_reg;
        fin_next          = fin_reg;
        phase_next        = phase_reg;
        walk_next         = walk_reg;
        acc_next          = acc_reg;
        bits_left_next    = bits_left_reg;
        pend_next         = pend_reg;
        produced_next     = produced_reg;
        consumed_next     = consumed_reg;
        ring_idx_next     = ring_idx_reg;
        wrapped_next      = wrapped_reg;
        plain_len_next    = plain_len_reg;
        stream_bytes_next = stream_bytes_reg;
        bit_next          = bit_reg;
        sym_next          = sym_reg;
        c_next            = c_reg;
        l_next            = l_reg;
        x_next            = x_reg;
        y_next            = y_reg;
        ia_next           = ia_reg;
        ib_next           = ib_reg;
        m_next            = m_reg;
        k_next            = k_reg;
        ca_next           = ca_reg;
        sum_next          = sum_reg;
        src_next          = src_reg;
        copy_left_next    = copy_left_reg;
        hist_valid_next   = hist_valid_reg;
        out_valid_next    = out_valid_reg && !m_tready;
        out_byte_next     = out_byte_reg;
        out_last_next     = out_last_reg;
        out_status_next   = out_status_reg;

        cnt_re = 1'b0; cnt_raddr = '0; cnt_we = 1'b0; cnt_waddr = '0; cnt_wdata = '0;
        par_re = 1'b0; par_raddr = '0; par_we = 1'b0; par_waddr = '0; par_wdata = '0;
        chd_re = 1'b0; chd_raddr = '0; chd_we = 1'b0; chd_waddr = '0; chd_wdata = '0;
        hist_re = 1'b0; hist_raddr = '0;

        emit_en   = 1'b0;
        emit_val  = '0;
        emit_last = 1'b0;
        walk_idx  = '0;
        acc8      = '0;
        bl_dec    = '0;
        pc        = '0;
        owed      = '0;
        src_tmp   = '0;

        s_tready = (state_reg == S_IDLE);

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_PLAIN_LENGTH: plain_len_next    = cfg_data;
                CFG_STREAM_BYTES: stream_bytes_next = cfg_data;
            endcase
        end

        unique case (state_reg)
            // Initial tree: leaves first, then pair sums up to the root.
            S_INIT_LEAF:
            begin
                cnt_we = 1'b1; cnt_waddr = ia_reg; cnt_wdata = count_t'(1);
                chd_we = 1'b1; chd_waddr = ia_reg; chd_wdata = ia_reg + N_TNODES;
                par_we = 1'b1; par_waddr = ia_reg + N_TNODES; par_wdata = ia_reg;
                if (ia_reg == N_NSYM_LAST)
                begin
                    ia_next    = '0;
                    ib_next    = N_NSYM;
                    state_next = S_INIT_RA;
                end
                else
                begin
                    ia_next = ia_reg + node_t'(1);
                end
            end
            S_INIT_RA:
            begin
                cnt_re = 1'b1; cnt_raddr = ia_reg;
                state_next = S_INIT_RB;
            end
            S_INIT_RB:
            begin
                ca_next = cnt_rdata_reg;
                cnt_re = 1'b1; cnt_raddr = ia_reg + node_t'(1);
                state_next = S_INIT_W;
            end
            S_INIT_W:
            begin
                cnt_we = 1'b1; cnt_waddr = ib_reg; cnt_wdata = ca_reg + cnt_rdata_reg;
                chd_we = 1'b1; chd_waddr = ib_reg; chd_wdata = ia_reg;
                par_we = 1'b1; par_waddr = ia_reg; par_wdata = ib_reg;
                state_next = S_INIT_W2;
            end
            S_INIT_W2:
            begin
                par_we = 1'b1; par_waddr = ia_reg + node_t'(1); par_wdata = ib_reg;
                if (ib_reg == N_ROOT)
                begin
                    state_next = S_INIT_FIN;
                end
                else
                begin
                    ia_next    = ia_reg + node_t'(2);
                    ib_next    = ib_reg + node_t'(1);
                    state_next = S_INIT_RA;
                end
            end
            S_INIT_FIN:
            begin
                cnt_we = 1'b1; cnt_waddr = N_TNODES; cnt_wdata = COUNT_SENT;
                par_we = 1'b1; par_waddr = N_ROOT; par_wdata = '0;
                state_next = S_IDLE;
            end

            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    bit_next = s_tdata[0];
                    if (fin_reg != FIN_RUN)
                    begin
                        // Bits after the end are dropped.
                    end
                    else if (produced_reg >= plain_len_reg)
                    begin
                        fin_next = FIN_DONE;
                    end
                    else if (stream_bytes_reg == 32'd0)
                    begin
                        state_next = S_FAIL;
                    end
                    else
                    begin
                        if (consumed_reg != '1)
                        begin
                            consumed_next = consumed_reg + 35'd1;
                        end
                        case (phase_reg)
                            PH_BYTE:
                            begin
                                acc8   = {acc_reg[6:0], s_tdata[0]};
                                bl_dec = (bits_left_reg == '0) ? '0 : bits_left_reg - 4'd1;
                                acc_next = {4'd0, acc8};
                                bits_left_next = bl_dec;
                                if (bl_dec == '0)
                                begin
                                    pc             = pos_lookup(acc8);
                                    acc_next       = {pc.code, acc8[5:0]};
                                    bits_left_next = pc.len - 4'd2;
                                    phase_next     = PH_EXTRA;
                                end
                            end
                            PH_EXTRA:
                            begin
                                acc_next = {acc_reg[11:6], acc_reg[4:0], s_tdata[0]};
                                bl_dec = (bits_left_reg == '0) ? '0 : bits_left_reg - 4'd1;
                                bits_left_next = bl_dec;
                                if (bl_dec == '0)
                                begin
                                    phase_next = PH_WALK;
                                    state_next = S_MATCH_CHK;
                                end
                            end
                            default:
                            begin
                                phase_next = PH_WALK;
                                walk_idx = {1'b0, walk_reg} + (NODE_W + 1)'(s_tdata[0]);
                                if (walk_idx >= (NODE_W + 1)'(TNODES))
                                begin
                                    state_next = S_FAIL;
                                end
                                else
                                begin
                                    chd_re = 1'b1; chd_raddr = walk_idx[NODE_W-1:0];
                                    state_next = S_WALK_CHILD;
                                end
                            end
                        endcase
                    end
                end
            end

            S_FAIL:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_byte_next   = '0;
                    out_last_next   = 1'b1;
                    out_status_next = ST_ERROR;
                    fin_next        = FIN_ERR;
                    state_next      = S_IDLE;
                end
            end

            S_WALK_CHILD:
            begin
                if (chd_rdata_reg < N_TNODES)
                begin
                    walk_next  = chd_rdata_reg;
                    state_next = S_IDLE;
                end
                else if (chd_rdata_reg >= N_PAR_DEPTH)
                begin
                    state_next = S_FAIL;
                end
                else
                begin
                    sym_next = SYM_W'(chd_rdata_reg - N_TNODES);
                    cnt_re = 1'b1; cnt_raddr = N_ROOT;
                    state_next = S_BUMP_ROOTW;
                end
            end

            // Count update: climb from the leaf, swapping ahead of larger counts.
            S_BUMP_ROOTW:
            begin
                if (cnt_rdata_reg == COUNT_LIMIT)
                begin
                    ia_next    = '0;
                    ib_next    = '0;
                    state_next = S_RB_RD;
                end
                else
                begin
                    par_re = 1'b1; par_raddr = node_t'(sym_reg) + N_TNODES;
                    state_next = S_BUMP_LEAFW;
                end
            end
            S_BUMP_LEAF:
            begin
                par_re = 1'b1; par_raddr = node_t'(sym_reg) + N_TNODES;
                state_next = S_BUMP_LEAFW;
            end
            S_BUMP_LEAFW:
            begin
                c_next     = par_rdata_reg;
                state_next = S_BUMP_TOP;
            end
            S_BUMP_TOP:
            begin
                if (c_reg >= N_TNODES)
                begin
                    state_next = S_FAIL;
                end
                else
                begin
                    cnt_re = 1'b1; cnt_raddr = c_reg;
                    state_next = S_BUMP_INC;
                end
            end
            S_BUMP_INC:
            begin
                k_next = cnt_rdata_reg + count_t'(1);
                cnt_we = 1'b1; cnt_waddr = c_reg; cnt_wdata = cnt_rdata_reg + count_t'(1);
                l_next = c_reg + node_t'(1);
                cnt_re = 1'b1; cnt_raddr = c_reg + node_t'(1);
                state_next = S_BUMP_CMP;
            end
            S_BUMP_CMP:
            begin
                if (k_reg > cnt_rdata_reg)
                begin
                    if (l_reg < N_TNODES)
                    begin
                        l_next = l_reg + node_t'(1);
                        cnt_re = 1'b1; cnt_raddr = l_reg + node_t'(1);
                        state_next = S_BUMP_SCAN;
                    end
                    else
                    begin
                        state_next = S_FAIL;
                    end
                end
                else
                begin
                    state_next = S_BUMP_UP;
                end
            end
            S_BUMP_SCAN:
            begin
                if ((l_reg < N_TNODES) && (k_reg > cnt_rdata_reg))
                begin
                    l_next = l_reg + node_t'(1);
                    cnt_re = 1'b1; cnt_raddr = l_reg + node_t'(1);
                end
                else if (k_reg > cnt_rdata_reg)
                begin
                    state_next = S_FAIL;
                end
                else
                begin
                    l_next = l_reg - node_t'(1);
                    cnt_re = 1'b1; cnt_raddr = l_reg - node_t'(1);
                    chd_re = 1'b1; chd_raddr = c_reg;
                    state_next = S_SWAP1;
                end
            end
            S_SWAP1:
            begin
                cnt_we = 1'b1; cnt_waddr = c_reg; cnt_wdata = cnt_rdata_reg;
                x_next = chd_rdata_reg;
                chd_re = 1'b1; chd_raddr = l_reg;
                state_next = (chd_rdata_reg >= N_PAR_DEPTH) ? S_FAIL : S_SWAP2;
            end
            S_SWAP2:
            begin
                cnt_we = 1'b1; cnt_waddr = l_reg; cnt_wdata = k_reg;
                par_we = 1'b1; par_waddr = x_reg; par_wdata = l_reg;
                chd_we = 1'b1; chd_waddr = l_reg; chd_wdata = x_reg;
                y_next = chd_rdata_reg;
                state_next = (chd_rdata_reg >= N_PAR_DEPTH) ? S_FAIL : S_SWAP3;
            end
            S_SWAP3:
            begin
                if (x_reg < N_TNODES)
                begin
                    par_we = 1'b1; par_waddr = x_reg + node_t'(1); par_wdata = l_reg;
                end
                state_next = S_SWAP4;
            end
            S_SWAP4:
            begin
                par_we = 1'b1; par_waddr = y_reg; par_wdata = c_reg;
                state_next = S_SWAP5;
            end
            S_SWAP5:
            begin
                if (y_reg < N_TNODES)
                begin
                    par_we = 1'b1; par_waddr = y_reg + node_t'(1); par_wdata = c_reg;
                end
                chd_we = 1'b1; chd_waddr = c_reg; chd_wdata = y_reg;
                c_next = l_reg;
                state_next = S_BUMP_UP;
            end
            S_BUMP_UP:
            begin
                par_re = 1'b1; par_raddr = c_reg;
                state_next = S_BUMP_UPW;
            end
            S_BUMP_UPW:
            begin
                c_next = par_rdata_reg;
                if (par_rdata_reg != '0)
                begin
                    state_next = S_BUMP_TOP;
                end
                else
                begin
                    chd_re = 1'b1; chd_raddr = N_ROOT;
                    state_next = S_BUMP_ENDW;
                end
            end
            S_BUMP_ENDW:
            begin
                walk_next = chd_rdata_reg;
                if (overrun)
                begin
                    state_next = S_FAIL;
                end
                else if (!sym_reg[SYM_W-1])
                begin
                    state_next = S_LIT;
                end
                else
                begin
                    pend_next      = LEN_W'(sym_reg - MATCH_BIAS);
                    acc_next       = '0;
                    bits_left_next = 4'd8;
                    phase_next     = PH_BYTE;
                    state_next     = S_IDLE;
                end
            end

            // Rebuild, first pass: gather leaves to the front with halved counts.
            S_RB_RD:
            begin
                cnt_re = 1'b1; cnt_raddr = ia_reg;
                chd_re = 1'b1; chd_raddr = ia_reg;
                state_next = S_RB_CMP;
            end
            S_RB_CMP:
            begin
                if (chd_rdata_reg >= N_TNODES)
                begin
                    sum_next  = ({1'b0, cnt_rdata_reg} + 17'd1) >> 1;
                    cnt_we    = 1'b1; cnt_waddr = ib_reg;
                    cnt_wdata = COUNT_W'(({1'b0, cnt_rdata_reg} + 17'd1) >> 1);
                    chd_we    = 1'b1; chd_waddr = ib_reg; chd_wdata = chd_rdata_reg;
                    ib_next   = ib_reg + node_t'(1);
                end
                if (ia_reg == N_ROOT)
                begin
                    ia_next    = '0;
                    ib_next    = N_NSYM;
                    state_next = S_RB_RA;
                end
                else
                begin
                    ia_next    = ia_reg + node_t'(1);
                    state_next = S_RB_RD;
                end
            end
            // Second pass: insert each pair sum at its sorted place.
            S_RB_RA:
            begin
                cnt_re = 1'b1; cnt_raddr = ia_reg;
                state_next = S_RB_RB;
            end
            S_RB_RB:
            begin
                ca_next = cnt_rdata_reg;
                cnt_re = 1'b1; cnt_raddr = ia_reg + node_t'(1);
                state_next = S_RB_SUM;
            end
            S_RB_SUM:
            begin
                sum_next = {1'b0, ca_reg} + {1'b0, cnt_rdata_reg};
                l_next   = ib_reg - node_t'(1);
                cnt_re = 1'b1; cnt_raddr = ib_reg - node_t'(1);
                state_next = S_RB_SRCH;
            end
            S_RB_SRCH:
            begin
                if ((l_reg != '0) && (sum_reg < {1'b0, cnt_rdata_reg}))
                begin
                    l_next = l_reg - node_t'(1);
                    cnt_re = 1'b1; cnt_raddr = l_reg - node_t'(1);
                end
                else
                begin
                    if (sum_reg >= {1'b0, cnt_rdata_reg})
                    begin
                        l_next = l_reg + node_t'(1);
                    end
                    m_next     = ib_reg;
                    state_next = S_RB_SH;
                end
            end
            S_RB_SH:
            begin
                if (m_reg > l_reg)
                begin
                    cnt_re = 1'b1; cnt_raddr = m_reg - node_t'(1);
                    chd_re = 1'b1; chd_raddr = m_reg - node_t'(1);
                    state_next = S_RB_SHW;
                end
                else
                begin
                    cnt_we = 1'b1; cnt_waddr = l_reg; cnt_wdata = sum_reg[COUNT_W-1:0];
                    chd_we = 1'b1; chd_waddr = l_reg; chd_wdata = ia_reg;
                    if (ib_reg == N_ROOT)
                    begin
                        ia_next    = '0;
                        state_next = S_RB_PR;
                    end
                    else
                    begin
                        ia_next    = ia_reg + node_t'(2);
                        ib_next    = ib_reg + node_t'(1);
                        state_next = S_RB_RA;
                    end
                end
            end
            S_RB_SHW:
            begin
                cnt_we = 1'b1; cnt_waddr = m_reg; cnt_wdata = cnt_rdata_reg;
                chd_we = 1'b1; chd_waddr = m_reg; chd_wdata = chd_rdata_reg;
                m_next = m_reg - node_t'(1);
                state_next = S_RB_SH;
            end
            // Third pass: parents from the new child links.
            S_RB_PR:
            begin
                chd_re = 1'b1; chd_raddr = ia_reg;
                state_next = S_RB_PW;
            end
            S_RB_PW:
            begin
                x_next = chd_rdata_reg;
                if (chd_rdata_reg < N_PAR_DEPTH)
                begin
                    par_we = 1'b1; par_waddr = chd_rdata_reg; par_wdata = ia_reg;
                end
                state_next = S_RB_PW2;
            end
            S_RB_PW2:
            begin
                if (x_reg < N_TNODES)
                begin
                    par_we = 1'b1; par_waddr = x_reg + node_t'(1); par_wdata = ia_reg;
                end
                if (ia_reg == N_ROOT)
                begin
                    state_next = S_BUMP_LEAF;
                end
                else
                begin
                    ia_next    = ia_reg + node_t'(1);
                    state_next = S_RB_PR;
                end
            end

            S_LIT:
            begin
                if (out_free)
                begin
                    emit_en    = 1'b1;
                    emit_val   = sym_reg[7:0];
                    emit_last  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_MATCH_CHK:
            begin
                if (overrun)
                begin
                    state_next = S_FAIL;
                end
                else
                begin
                    owed = plain_len_reg - produced_reg;
                    copy_left_next = (32'(pend_reg) > owed) ? owed[LEN_W-1:0] : pend_reg;
                    src_tmp = {1'b0, ring_idx_reg} + RING_EXT - (RING_AW + 1)'(acc_reg)
                              - (RING_AW + 1)'(1);
                    if (src_tmp >= RING_EXT)
                    begin
                        src_tmp = src_tmp - RING_EXT;
                    end
                    src_next = src_tmp[RING_AW-1:0];
                    if ((32'(pend_reg) > owed) ? (owed == 32'd0) : (pend_reg == '0))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_COPY_RD;
                    end
                end
            end
            S_COPY_RD:
            begin
                hist_re = 1'b1; hist_raddr = src_reg;
                // Entries past the fill pointer show as FILL_BYTE spaces, not the ring byte.
                hist_valid_next = wrapped_reg || (src_reg < ring_idx_reg);
                state_next = S_COPY_OUT;
            end
            S_COPY_OUT:
            begin
                if (out_free)
                begin
                    emit_en   = 1'b1;
                    emit_val  = hist_valid_reg ? hist_rdata_reg : FILL_BYTE;
                    emit_last = (copy_left_reg == LEN_W'(1));
                    src_next  = (src_reg == RING_LAST) ? '0 : src_reg + RING_AW'(1);
                    copy_left_next = copy_left_reg - LEN_W'(1);
                    state_next = (copy_left_reg == LEN_W'(1)) ? S_IDLE : S_COPY_RD;
                end
            end
        endcase

        // One plaintext byte: result register, ring write and counters.
        emit_count = produced_reg + 32'd1;
        hist_we    = emit_en;
        hist_waddr = ring_idx_reg;
        hist_wdata = emit_val;
        if (emit_en)
        begin
            out_valid_next  = 1'b1;
            out_byte_next   = emit_val;
            out_last_next   = emit_last;
            out_status_next = (emit_count == plain_len_reg) ? ST_FINAL : ST_OK;
            produced_next   = emit_count;
            if (emit_count == plain_len_reg)
            begin
                fin_next = FIN_DONE;
            end
            if (ring_idx_reg == RING_LAST)
            begin
                ring_idx_next = '0;
                wrapped_next  = 1'b1;
            end
            else
            begin
                ring_idx_next = ring_idx_reg + RING_AW'(1);
            end
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_byte_reg;
    assign m_tlast   = out_last_reg;
    assign m_tuser   = out_status_reg;

`ifndef ASSERT_OFF
    a_error_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == ST_ERROR)) |-> (m_tlast && (m_tdata == 8'd0)))
        else $error("error result must be a zero byte marked last");

    a_error_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && (m_tuser == ST_ERROR)) |=> (fin_reg == FIN_ERR))
        else $error("decoder left the error state after reporting it");

    a_final_done: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == ST_FINAL)) |-> (fin_reg == FIN_DONE))
        else $error("final byte shown while the decoder is still running");

    a_copy_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COPY_OUT) |-> (copy_left_reg != '0))
        else $error("match copy running with no bytes left");
`endif

endmodule

// ===== sim/tb_lzhuf_adaptive_huffman_decoder.sv =====
// Self-checking testbench for the bit-serial LZHUF decoder: encodes symbols against
// its own copy of the adaptive tree and predicts every plaintext byte and status.
// Depends on lzhuf_pkg and lzhuf_adaptive_huffman_decoder.

module tb_lzhuf_adaptive_huffman_decoder;
    import lzhuf_pkg::*;

    localparam int RING_N = 8192;
    localparam int SLACK  = 8;
    localparam int HALF_PERIOD = 10;
    localparam logic [34:0] BITS_SAT = '1;
    localparam int POS_SPLIT [6] = '{1, 3, 8, 12, 24, 16};

    typedef struct {
        logic [7:0] data;
        logic       last;
        status_t    st;
    } plain_out_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [31:0] cfg_data;

    // Decoder state mirrored from the block's behavior.
    count_t      tree_cnt [0:TNODES];
    node_t       tree_up [0:PAR_DEPTH-1];
    node_t       tree_down [0:TNODES-1];
    logic [7:0]  hist [0:RING_N-1];
    logic [12:0] hist_pos;
    phase_t      dec_phase;
    int          walk_at;
    logic [15:0] pos_acc;
    int          extra_left;
    int          match_len;
    logic [31:0] produced;
    logic [34:0] bits_in;
    fin_t        dec_fin;
    logic [31:0] plain_len_reg;
    logic [31:0] stream_len_reg;

    plain_out_t  expected_bytes [$];
    int          mismatches;
    int          bytes_checked;
    int          bits_sent;
    int          symbols_sent;
    bit          sender_idles;
    bit          receiver_idles;
    int          hold_cycles;

    lzhuf_adaptive_huffman_decoder DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #HALF_PERIOD;
        clk = 1'b1;
        #HALF_PERIOD;
    end

    initial
    begin
        #200_000_000;
        $display("FAILURE");
        $finish;
    end

    // ---------------- prediction ----------------

    task automatic tree_reset();
        int a;
        for (int s = 0; s < NSYM; s++)
        begin
            tree_cnt[s]           = 16'd1;
            tree_down[s]          = node_t'(s + TNODES);
            tree_up[s + TNODES]   = node_t'(s);
        end
        a = 0;
        for (int b = NSYM; b <= ROOT; b++)
        begin
            tree_cnt[b]    = tree_cnt[a] + tree_cnt[a + 1];
            tree_down[b]   = node_t'(a);
            tree_up[a]     = node_t'(b);
            tree_up[a + 1] = node_t'(b);
            a += 2;
        end
        tree_cnt[TNODES] = COUNT_SENT;
        tree_up[ROOT]    = '0;
    endtask

    function automatic void tree_halve();
        int b;
        int a;
        int k;
        int sum;
        b = 0;
        for (a = 0; a < TNODES; a++)
        begin
            if (tree_down[a] >= TNODES)
            begin
                tree_cnt[b]  = count_t'((int'(tree_cnt[a]) + 1) / 2);
                tree_down[b] = tree_down[a];
                b++;
            end
        end
        a = 0;
        for (b = NSYM; b < TNODES; b++)
        begin
            sum = int'(tree_cnt[a]) + int'(tree_cnt[a + 1]);
            k = b - 1;
            while (k > 0 && sum < int'(tree_cnt[k]))
                k--;
            if (sum >= int'(tree_cnt[k]))
                k++;
            for (int m = b; m > k; m--)
            begin
                tree_cnt[m]  = tree_cnt[m - 1];
                tree_down[m] = tree_down[m - 1];
            end
            tree_cnt[k]  = count_t'(sum);
            tree_down[k] = node_t'(a);
            a += 2;
        end
        for (int n = 0; n < TNODES; n++)
        begin
            k = int'(tree_down[n]);
            if (k < PAR_DEPTH)
                tree_up[k] = node_t'(n);
            if (k < TNODES)
                tree_up[k + 1] = node_t'(n);
        end
    endfunction

    // Count a symbol (halving at the limit), keep sibling order; 0 on a tree fault.
    function automatic bit tree_count_symbol(int sym);
        int c;
        int k;
        int l;
        int x;
        int y;
        if (tree_cnt[ROOT] == COUNT_LIMIT)
            tree_halve();
        c = int'(tree_up[sym + TNODES]);
        do
        begin
            if (c >= TNODES)
                return 1'b0;
            k = (int'(tree_cnt[c]) + 1) & 16'hffff;
            tree_cnt[c] = count_t'(k);
            l = c + 1;
            if (k > int'(tree_cnt[l]))
            begin
                while (l < TNODES && k > int'(tree_cnt[l]))
                    l++;
                if (k > int'(tree_cnt[l]))
                    return 1'b0;
                l--;
                tree_cnt[c] = tree_cnt[l];
                tree_cnt[l] = count_t'(k);
                x = int'(tree_down[c]);
                if (x >= PAR_DEPTH)
                    return 1'b0;
                tree_up[x] = node_t'(l);
                if (x < TNODES)
                    tree_up[x + 1] = node_t'(l);
                y = int'(tree_down[l]);
                tree_down[l] = node_t'(x);
                if (y >= PAR_DEPTH)
                    return 1'b0;
                tree_up[y] = node_t'(c);
                if (y < TNODES)
                    tree_up[y + 1] = node_t'(c);
                tree_down[c] = node_t'(y);
                c = l;
            end
            c = int'(tree_up[c]);
        end
        while (c != 0);
        return 1'b1;
    endfunction

    function automatic bit over_fetch();
        longint unsigned fetched;
        fetched = 1 + (longint'(bits_in) + 7) / 8;
        return fetched > longint'(stream_len_reg) + SLACK;
    endfunction

    task automatic stream_error();
        plain_out_t r;
        dec_fin = FIN_ERR;
        r.data  = 8'h00;
        r.last  = 1'b1;
        r.st    = ST_ERROR;
        expected_bytes.push_back(r);
    endtask

    task automatic put_plain(logic [7:0] v);
        plain_out_t r;
        hist[hist_pos] = v;
        hist_pos++;
        produced++;
        r.data = v;
        r.last = 1'b0;
        r.st   = (produced == plain_len_reg) ? ST_FINAL : ST_OK;
        expected_bytes.push_back(r);
        if (produced == plain_len_reg)
            dec_fin = FIN_DONE;
    endtask

    task automatic decode_bit(bit b);
        int idx;
        int c;
        int n_out;
        int base;
        int code;
        int span;
        logic [12:0] src;
        logic [31:0] owed;
        if (dec_fin != FIN_RUN)
            return;
        if (produced >= plain_len_reg)
        begin
            dec_fin = FIN_DONE;
            return;
        end
        if (stream_len_reg == 0)
        begin
            stream_error();
            return;
        end
        if (bits_in != BITS_SAT)
            bits_in++;
        if (dec_phase == PH_BYTE)
        begin
            pos_acc = ((pos_acc << 1) | b) & 16'hff;
            if (extra_left > 0)
                extra_left--;
            if (extra_left == 0)
            begin
                // Map the first position byte to its code length and upper bits.
                base = 0;
                code = 0;
                extra_left = 6;
                c = 63;
                for (int g = 0; g < 6; g++)
                begin
                    span = 1 << (5 - g);
                    if (c == 63 && extra_left == 6 && int'(pos_acc) < base + POS_SPLIT[g] * span)
                    begin
                        c = code + (int'(pos_acc) - base) / span;
                        extra_left = g + 1;
                    end
                    base += POS_SPLIT[g] * span;
                    code += POS_SPLIT[g];
                end
                pos_acc = (16'(c) << 6) | (pos_acc & 16'h3f);
                dec_phase = PH_EXTRA;
            end
            return;
        end
        if (dec_phase == PH_EXTRA)
        begin
            pos_acc = (pos_acc & 16'hfc0) | (((pos_acc << 1) | b) & 16'h3f);
            if (extra_left > 0)
                extra_left--;
            if (extra_left != 0)
                return;
            dec_phase = PH_WALK;
            if (over_fetch())
            begin
                stream_error();
                return;
            end
            owed  = plain_len_reg - produced;
            n_out = (match_len > owed) ? int'(owed) : match_len;
            src   = hist_pos - 13'(pos_acc & 16'hfff) - 13'd1;
            for (int k = 0; k < n_out; k++)
            begin
                put_plain(hist[src]);
                src++;
            end
            if (n_out > 0)
                expected_bytes[$].last = 1'b1;
            return;
        end
        dec_phase = PH_WALK;
        idx = walk_at + b;
        if (idx >= TNODES)
        begin
            stream_error();
            return;
        end
        c = int'(tree_down[idx]);
        if (c < TNODES)
        begin
            walk_at = c;
            return;
        end
        c -= TNODES;
        if (c >= NSYM || !tree_count_symbol(c))
        begin
            stream_error();
            return;
        end
        walk_at = int'(tree_down[ROOT]);
        if (over_fetch())
        begin
            stream_error();
            return;
        end
        if (c < 256)
        begin
            put_plain(8'(c));
            expected_bytes[$].last = 1'b1;
            return;
        end
        match_len  = (c + 2 - 255) & 6'h3f;
        pos_acc    = '0;
        extra_left = 8;
        dec_phase  = PH_BYTE;
    endtask

    // ---------------- drivers and checker ----------------

    task automatic send_bit(bit b);
        decode_bit(b);
        if (sender_idles && $urandom_range(99) < 8)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        else
            @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, b};
        do
            @(posedge clk);
        while (!s_tready);
        bits_sent++;
    endtask

    task automatic send_symbol(int sym);
        bit path [$];
        int n;
        n = int'(tree_up[sym + TNODES]);
        while (n != ROOT)
        begin
            path.push_front(n[0]);
            n = int'(tree_up[n]);
        end
        symbols_sent++;
        foreach (path[i])
            send_bit(path[i]);
    endtask

    // A match with a chosen first position byte; the remaining bits repeat fill.
    task automatic send_match(int len, logic [7:0] pos_byte, bit fill);
        send_symbol(len + 253);
        for (int i = 7; i >= 0 && dec_phase == PH_BYTE && dec_fin == FIN_RUN; i--)
            send_bit(pos_byte[i]);
        while (dec_phase == PH_EXTRA && dec_fin == FIN_RUN)
            send_bit(fill);
    endtask

    task automatic send_random_match(int len);
        send_symbol(len + 253);
        while (dec_phase != PH_WALK && dec_fin == FIN_RUN)
            send_bit($urandom_range(1));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (expected_bytes.size() == 0);
        // A bit that ends a symbol may still be reordering the tree.
        repeat (6000) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_PLAIN_LENGTH)
            plain_len_reg = val;
        else
            stream_len_reg = val;
    endtask

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        $display("mismatch on byte %0d: %s got %0h expected %0h", bytes_checked, what, got, want);
    endtask

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_tready    <= 1'b0;
        end
        else
            m_tready <= !(receiver_idles && $urandom_range(99) < 8);
    end

    always @(posedge clk)
    begin
        plain_out_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_bytes.size() == 0)
                report_mismatch("unexpected transfer, data", m_tdata, 0);
            else
            begin
                want = expected_bytes.pop_front();
                if (m_tdata !== want.data)
                    report_mismatch("out_byte", m_tdata, want.data);
                if (m_tlast !== want.last)
                    report_mismatch("run_last", m_tlast, want.last);
                if (m_tuser !== want.st)
                    report_mismatch("status", m_tuser, want.st);
            end
            bytes_checked++;
        end
    end

    // ---------------- tests ----------------

    task automatic test_config_extremes();
        write_reg(CFG_PLAIN_LENGTH, 32'hffff_ffff);
        write_reg(CFG_STREAM_BYTES, 32'hffff_ffff);
    endtask

    task automatic test_directed_symbols();
        send_symbol(0);
        send_symbol(255);
        send_symbol(8'h41);
        send_match(3, 8'h00, 1'b0);
        send_match(MAX_MATCH, 8'hff, 1'b1);
        send_match(4, 8'hc5, 1'b1);
    endtask

    task automatic test_random_stream(int n_bits);
        int pick;
        int stop_at;
        stop_at = bits_sent + n_bits;
        while (bits_sent < stop_at)
        begin
            // No idling at all during the first stretch.
            sender_idles   = (bits_sent > stop_at - n_bits + 30);
            receiver_idles = sender_idles;
            pick = $urandom_range(99);
            if (pick < 55)
                send_symbol($urandom_range(255));
            else if (pick < 75)
                send_random_match((pick < 70) ? $urandom_range(3, 8) : $urandom_range(3, MAX_MATCH));
            else
                repeat (8) send_bit($urandom_range(1));
        end
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
    endtask

    task automatic test_backpressure();
        hold_cycles = 3000;
        repeat (3) send_random_match(MAX_MATCH);
        send_symbol($urandom_range(255));
    endtask

    task automatic test_config_change();
        wait_drained();
        write_reg(CFG_PLAIN_LENGTH, produced + 32'd100000);
        write_reg(CFG_STREAM_BYTES, 32'(bits_in / 8) + 32'd2000);
        test_random_stream(30);
    endtask

    // Only one ending per run is possible, since the decoder stops for good.
    task automatic test_ending();
        int mode;
        wait_drained();
        mode = $urandom_range(3);
        case (mode)
            0: write_reg(CFG_PLAIN_LENGTH, produced + 32'd1);
            1: write_reg(CFG_STREAM_BYTES, 32'd1);
            2: write_reg(CFG_STREAM_BYTES, 32'd0);
            default: write_reg(CFG_PLAIN_LENGTH, 32'd0);
        endcase
        send_match(MAX_MATCH, 8'h03, 1'b0);
        repeat (12) send_bit($urandom_range(1));
        $display("ending mode %0d, decoder state %s", mode, dec_fin.name());
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = 8'h00;
        m_tready       = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        mismatches     = 0;
        bytes_checked  = 0;
        bits_sent      = 0;
        symbols_sent   = 0;
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        hold_cycles    = 0;
        tree_reset();
        foreach (hist[i])
            hist[i] = FILL_BYTE;
        hist_pos       = '0;
        dec_phase      = PH_WALK;
        walk_at        = int'(tree_down[ROOT]);
        pos_acc        = '0;
        extra_left     = 0;
        match_len      = 0;
        produced       = '0;
        bits_in        = '0;
        dec_fin        = FIN_RUN;
        plain_len_reg  = '0;
        stream_len_reg = 32'd1;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_config_extremes();
        test_directed_symbols();
        test_random_stream(40);
        test_backpressure();
        test_config_change();
        test_ending();

        wait_drained();
        $display("sent %0d bits (%0d encoded symbols), checked %0d output transfers",
                 bits_sent, symbols_sent, bytes_checked);
        $display("covered literals, shortest and longest matches, back-pressure and one ending");
        if (mismatches == 0 && expected_bytes.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
